// File: design/chs_pkg.sv
package chs_pkg;

    localparam int KEY_W       = 32;
    localparam int CNT_W       = 5;
    localparam int BIDX_W      = 4;
    localparam int APB_AW      = 2;
    localparam int APB_DW      = 32;
    localparam int MOD_BITS    = 8;
    localparam int MOD_STEPS   = KEY_W / MOD_BITS;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [APB_AW-1:0] ADDR_BUCKET_COUNT  = 2'd0;
    localparam logic [CNT_W-1:0]  BUCKET_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_TEST  = 2'd1,
        ACT_ERASE = 2'd2,
        ACT_LIST  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_FILL,
        ST_SCAN,
        ST_EXEC,
        ST_SHIFT,
        ST_LIST,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } mod_res_t;

    typedef struct packed {
        logic              found;
        logic              status;
        logic [BIDX_W-1:0] bucket_index;
        logic [KEY_W-1:0]  entry_key;
        logic              entry_valid;
        logic              last;
    } result_t;

endpackage

// File: design/chs_mod_unit.sv
module chs_mod_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  chs_pkg::mod_req_t req,
    output chs_pkg::mod_res_t res
);
    import chs_pkg::*;

    localparam int STEP_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    logic [KEY_W-1:0]  div_reg;
    logic [KEY_W-1:0]  div_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  divisor_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    // Restoring remainder, several key bits per cycle, most significant first.
    always_comb
    begin
        logic [CNT_W:0] t;
        rem_next = rem_reg;
        div_next = div_reg;
        for (int i = 0; i < MOD_BITS; i++)
        begin
            t = {rem_next, div_next[KEY_W-1]};
            div_next = div_next << 1;
            if (t >= {1'b0, divisor_reg})
            begin
                t = t - {1'b0, divisor_reg};
            end
            rem_next = t[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MOD_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
        end
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg;

endmodule

// File: design/chs_regs.sv
module chs_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [chs_pkg::APB_AW-1:0]  paddr,
    input  logic [chs_pkg::APB_DW-1:0]  pwdata,
    output logic [chs_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [chs_pkg::CNT_W-1:0]   bucket_count
);
    import chs_pkg::*;

    logic [CNT_W-1:0] bucket_count_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_BUCKET_COUNT)
        begin
            bucket_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_BUCKET_COUNT)
        begin
            prdata = APB_DW'(bucket_count_reg);
        end
    end

    assign bucket_count = bucket_count_reg;

endmodule

// File: design/chs_engine.sv
module chs_engine #(
    parameter int N_BUCKETS    = 16,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [chs_pkg::CNT_W-1:0] bucket_count,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  chs_pkg::action_t          in_action,
    input  logic [chs_pkg::KEY_W-1:0] in_key,
    output chs_pkg::mod_req_t         mod_req,
    input  chs_pkg::mod_res_t         mod_res,
    output logic                      out_valid,
    input  logic                      out_ready,
    output chs_pkg::result_t          out_item
);
    import chs_pkg::*;

    localparam int BKW       = (N_BUCKETS > 1) ? $clog2(N_BUCKETS) : 1;
    localparam int SW        = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FW        = $clog2(BUCKET_DEPTH + 1);
    localparam int EAW       = BKW + SW;
    localparam int ENT_DEPTH = N_BUCKETS << SW;

    logic [KEY_W-1:0] entry_mem [ENT_DEPTH];
    logic [FW-1:0]    fill_mem  [N_BUCKETS];

    state_t           state_reg, state_next;
    action_t          action_reg, action_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] bkt_reg, bkt_next;
    logic [FW-1:0]    n_reg, n_next;
    logic             found_reg, found_next;
    logic             status_reg, status_next;
    logic [FW-1:0]    pos_reg, pos_next;
    logic [FW-1:0]    issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [FW-1:0]    pend_idx_reg, pend_idx_next;
    logic [FW-1:0]    idx_reg, idx_next;
    logic [BKW-1:0]   clr_reg, clr_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_item_reg, out_item_next;

    logic             ent_we, ent_re;
    logic [EAW-1:0]   ent_waddr, ent_raddr;
    logic [KEY_W-1:0] ent_wdata;
    logic [KEY_W-1:0] ent_rdata_reg;
    logic             fill_we, fill_re;
    logic [BKW-1:0]   fill_waddr, fill_raddr;
    logic [FW-1:0]    fill_wdata;
    logic [FW-1:0]    fill_rdata_reg;

    logic [BKW-1:0]   bkt_addr;
    logic [CNT_W-1:0] divisor;
    logic             can_load;
    logic             match;
    logic             scan_done;
    logic             pos_has_next;
    logic             shift_more;
    logic [FW-1:0]    pos_p1, idx_p1, idx_p2, idx_m1, n_m1, n_p1;

    assign bkt_addr     = BKW'(bkt_reg);
    assign can_load     = !out_valid_reg || out_ready;
    assign match        = pend_reg && (ent_rdata_reg == key_reg);
    assign scan_done    = match || (issue_reg >= n_reg);
    assign pos_p1       = pos_reg + FW'(1);
    assign idx_p1       = idx_reg + FW'(1);
    assign idx_p2       = idx_reg + FW'(2);
    assign idx_m1       = idx_reg - FW'(1);
    assign n_m1         = n_reg - FW'(1);
    assign n_p1         = n_reg + FW'(1);
    assign pos_has_next = ({1'b0, pos_reg} + (FW+1)'(1)) < {1'b0, n_reg};
    assign shift_more   = ({1'b0, idx_reg} + (FW+1)'(2)) < {1'b0, n_reg};

    always_comb
    begin
        if (bucket_count == '0)
        begin
            divisor = CNT_W'(1);
        end
        else if (int'(bucket_count) > N_BUCKETS)
        begin
            divisor = CNT_W'(N_BUCKETS);
        end
        else
        begin
            divisor = bucket_count;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == BKW'(N_BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_res.done)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (action_reg)
                    ACT_ADD, ACT_TEST:
                    begin
                        state_next = ST_RESP;
                    end
                    ACT_ERASE:
                    begin
                        state_next = (found_reg && pos_has_next) ? ST_SHIFT : ST_RESP;
                    end
                    ACT_LIST:
                    begin
                        state_next = (n_reg == '0) ? ST_RESP : ST_LIST;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_SHIFT:
            begin
                if (!shift_more)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_LIST:
            begin
                if (can_load && idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        action_next    = action_reg;
        key_next       = key_reg;
        bkt_next       = bkt_reg;
        n_next         = n_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        idx_next       = idx_reg;
        clr_next       = clr_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        mod_req.start    = 1'b0;
        mod_req.dividend = in_key;
        mod_req.divisor  = divisor;

        ent_we     = 1'b0;
        ent_waddr  = '0;
        ent_wdata  = key_reg;
        ent_re     = 1'b0;
        ent_raddr  = '0;
        fill_we    = 1'b0;
        fill_waddr = bkt_addr;
        fill_wdata = '0;
        fill_re    = 1'b0;
        fill_raddr = BKW'(mod_res.rem);

        unique case (state_reg)
            ST_CLEAR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                clr_next   = clr_reg + BKW'(1);
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    action_next   = in_action;
                    key_next      = in_key;
                    found_next    = 1'b0;
                    status_next   = 1'b0;
                    mod_req.start = 1'b1;
                end
            end
            ST_MOD:
            begin
                if (mod_res.done)
                begin
                    bkt_next = mod_res.rem;
                    fill_re  = 1'b1;
                end
            end
            ST_FILL:
            begin
                n_next     = fill_rdata_reg;
                issue_next = '0;
                pend_next  = 1'b0;
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    pos_next   = pend_idx_reg;
                    pend_next  = 1'b0;
                end
                else if (issue_reg < n_reg)
                begin
                    ent_re        = 1'b1;
                    ent_raddr     = {bkt_addr, issue_reg[SW-1:0]};
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg;
                    issue_next    = issue_reg + FW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_EXEC:
            begin
                unique case (action_reg)
                    ACT_ADD:
                    begin
                        if (!found_reg)
                        begin
                            if (n_reg >= FW'(BUCKET_DEPTH))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                ent_we     = 1'b1;
                                ent_waddr  = {bkt_addr, n_reg[SW-1:0]};
                                fill_we    = 1'b1;
                                fill_wdata = n_p1;
                            end
                        end
                    end
                    ACT_ERASE:
                    begin
                        if (found_reg)
                        begin
                            fill_we    = 1'b1;
                            fill_wdata = n_m1;
                            if (pos_has_next)
                            begin
                                ent_re    = 1'b1;
                                ent_raddr = {bkt_addr, pos_p1[SW-1:0]};
                                idx_next  = pos_reg;
                            end
                        end
                    end
                    ACT_LIST:
                    begin
                        if (n_reg != '0)
                        begin
                            ent_re    = 1'b1;
                            ent_raddr = {bkt_addr, n_m1[SW-1:0]};
                            idx_next  = n_m1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SHIFT:
            begin
                ent_we    = 1'b1;
                ent_waddr = {bkt_addr, idx_reg[SW-1:0]};
                ent_wdata = ent_rdata_reg;
                idx_next  = idx_p1;
                if (shift_more)
                begin
                    ent_re    = 1'b1;
                    ent_raddr = {bkt_addr, idx_p2[SW-1:0]};
                end
            end
            ST_LIST:
            begin
                if (can_load)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.found        = found_reg;
                    out_item_next.status       = 1'b0;
                    out_item_next.bucket_index = bkt_reg[BIDX_W-1:0];
                    out_item_next.entry_key    = ent_rdata_reg;
                    out_item_next.entry_valid  = 1'b1;
                    out_item_next.last         = (idx_reg == '0);
                    if (idx_reg != '0)
                    begin
                        ent_re    = 1'b1;
                        ent_raddr = {bkt_addr, idx_m1[SW-1:0]};
                        idx_next  = idx_m1;
                    end
                end
            end
            ST_RESP:
            begin
                if (can_load)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.found        = found_reg;
                    out_item_next.status       = status_reg;
                    out_item_next.bucket_index = bkt_reg[BIDX_W-1:0];
                    out_item_next.entry_key    = '0;
                    out_item_next.entry_valid  = 1'b0;
                    out_item_next.last         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        key_reg      <= key_next;
        bkt_reg      <= bkt_next;
        n_reg        <= n_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        pos_reg      <= pos_next;
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        idx_reg      <= idx_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_rdata_reg <= entry_mem[ent_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (fill_re)
        begin
            fill_rdata_reg <= fill_mem[fill_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: design/chained_hash_set.sv
// Set of 32-bit keys held in bounded buckets, the bucket being the key modulo
// the active bucket count. Each input word adds, tests, erases or lists; list
// returns the bucket's keys newest first with tlast on the final word, every
// other action returns one word. Items are handled one at a time. An add or a
// test goes from its acceptance to the acceptance of the next word through
// these steps, n being the fill of its bucket: the accepting step, four
// remainder steps of eight key bits each, a step that flags the remainder and
// reads the bucket fill, one that takes the fill, a scan through the
// single-read-port entry memory that ends on a match or after the n entries,
// one step to act and one to load the result word. An erase of a present key
// then moves the later entries down at one per cycle, and a list replaces the
// result step by one word per cycle while the output is taken. After reset the
// fill memory is cleared bucket by bucket, and no input word is accepted
// meanwhile; configuration writes are taken at any time.
module chained_hash_set #(
    parameter int N_BUCKETS    = 16,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [chs_pkg::APB_AW-1:0]        paddr,
    input  logic [chs_pkg::APB_DW-1:0]        pwdata,
    output logic [chs_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // action[1:0], key[33:2], zero padding
    input  logic [chs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // found[0], status[1], bucket_index[5:2], entry_key[37:6],
    // entry_valid[38], zero padding
    output logic [chs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);
    import chs_pkg::*;

    logic [CNT_W-1:0] bucket_count;
    mod_req_t         mod_req;
    mod_res_t         mod_res;
    result_t          out_item;

    chs_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .bucket_count (bucket_count)
    );

    chs_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .res   (mod_res)
    );

    chs_engine #(
        .N_BUCKETS    (N_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .bucket_count (bucket_count),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_action    (action_t'(s_axis_tdata[1:0])),
        .in_key       (s_axis_tdata[KEY_W+1:2]),
        .mod_req      (mod_req),
        .mod_res      (mod_res),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_item     (out_item)
    );

    assign m_axis_tdata = {1'b0, out_item.entry_valid, out_item.entry_key,
                           out_item.bucket_index, out_item.status, out_item.found};
    assign m_axis_tlast = out_item.last;

endmodule

// File: tb/set_op_checker.sv
module set_op_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [chs_pkg::APB_AW-1:0]      paddr,
    input  logic [chs_pkg::APB_DW-1:0]      pwdata,
    input  logic                            pready,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [chs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [chs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            m_axis_tlast,
    output int                              mismatches,
    output int                              pending
);
    import chs_pkg::*;

    localparam int NB    = 16;
    localparam int DEPTH = 8;

    logic [KEY_W-1:0] slots [NB][DEPTH];
    int               fill [NB];
    logic [CNT_W-1:0] active_count;
    result_t          due_words [$];

    task automatic apply_set_op(input action_t act, input logic [KEY_W-1:0] key);
        int      nb;
        int      b;
        int      pos;
        result_t w;
        nb = (active_count == 0) ? 1 : ((active_count > NB) ? NB : int'(active_count));
        b = int'(key % KEY_W'(nb));
        pos = -1;
        for (int i = 0; i < fill[b]; i++)
        begin
            if (pos < 0 && slots[b][i] == key)
                pos = i;
        end
        w = '0;
        w.found = (pos >= 0);
        w.bucket_index = b[BIDX_W-1:0];
        w.last = 1'b1;
        case (act)
            ACT_ADD:
            begin
                if (pos < 0)
                begin
                    if (fill[b] >= DEPTH)
                        w.status = 1'b1;
                    else
                    begin
                        slots[b][fill[b]] = key;
                        fill[b]++;
                    end
                end
            end
            ACT_ERASE:
            begin
                if (pos >= 0)
                begin
                    for (int i = pos; i + 1 < fill[b]; i++)
                        slots[b][i] = slots[b][i + 1];
                    fill[b]--;
                end
            end
            default:
            begin
            end
        endcase
        if (act == ACT_LIST && fill[b] > 0)
        begin
            w.entry_valid = 1'b1;
            for (int i = 0; i < fill[b]; i++)
            begin
                w.entry_key = slots[b][fill[b] - 1 - i];
                w.last = (i + 1 == fill[b]);
                due_words.push_back(w);
            end
        end
        else
            due_words.push_back(w);
    endtask

    task automatic compare_field(input string name, input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_word();
        result_t w;
        if (due_words.size() == 0)
        begin
            $error("output word with nothing expected: tdata 0x%0h", m_axis_tdata);
            mismatches++;
        end
        else
        begin
            w = due_words.pop_front();
            compare_field("found", KEY_W'(w.found), KEY_W'(m_axis_tdata[0]));
            compare_field("status", KEY_W'(w.status), KEY_W'(m_axis_tdata[1]));
            compare_field("bucket_index", KEY_W'(w.bucket_index), KEY_W'(m_axis_tdata[5:2]));
            compare_field("entry_key", w.entry_key, m_axis_tdata[37:6]);
            compare_field("entry_valid", KEY_W'(w.entry_valid), KEY_W'(m_axis_tdata[38]));
            compare_field("last", KEY_W'(w.last), KEY_W'(m_axis_tlast));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NB; b++)
            begin
                fill[b] = 0;
                for (int i = 0; i < DEPTH; i++)
                    slots[b][i] = '0;
            end
            active_count = BUCKET_COUNT_RESET;
            due_words.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_BUCKET_COUNT)
                active_count = pwdata[CNT_W-1:0];
            if (s_axis_tvalid && s_axis_tready)
                apply_set_op(action_t'(s_axis_tdata[1:0]), s_axis_tdata[33:2]);
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            pending <= due_words.size();
        end
    end

endmodule

// File: tb/tb.sv
module tb;

    import chs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 36;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    int                     mismatches;
    int                     pending;

    logic                   idle_on;
    int                     ready_hold;
    int                     cycles = 0;
    logic [KEY_W-1:0]       key_pool [16];
    logic [CNT_W-1:0]       phase_counts [8];

    chained_hash_set dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    set_op_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            ready_hold = 0;
            m_axis_tready <= 1'b0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            ready_hold = $urandom_range(1, 3) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic write_count(input logic [CNT_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BUCKET_COUNT;
        pwdata <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(input action_t act, input logic [KEY_W-1:0] key);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tdata <= {6'b0, key, act};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_random_item();
        int               r;
        action_t          act;
        logic [KEY_W-1:0] key;
        r = $urandom_range(0, 9);
        act = (r < 4) ? ACT_ADD : (r < 6) ? ACT_TEST : (r < 8) ? ACT_ERASE : ACT_LIST;
        r = $urandom_range(0, 9);
        if (r < 5)
            key = key_pool[$urandom_range(0, 15)];
        else if (r < 8)
            key = $urandom_range(0, 47);
        else
            key = $urandom;
        if (act == ACT_ADD)
            key_pool[$urandom_range(0, 15)] = key;
        send_item(act, key);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        idle_on = 1'b1;
        for (int i = 0; i < 16; i++)
            key_pool[i] = KEY_W'(i * 3);
        phase_counts = '{5'd1, 5'd0, 5'd31, 5'd7, 5'd16, 5'd2, 5'd13, 5'd16};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_count(5'd16);

        send_item(ACT_ADD, 32'h0000_0000);
        send_item(ACT_ADD, 32'hFFFF_FFFF);
        send_item(ACT_ADD, 32'h0000_0000);
        send_item(ACT_TEST, 32'h0000_0000);
        send_item(ACT_TEST, 32'h0000_0010);
        send_item(ACT_LIST, 32'h0000_000F);
        send_item(ACT_LIST, 32'h0000_0003);
        send_item(ACT_ERASE, 32'hFFFF_FFFF);
        send_item(ACT_ERASE, 32'hFFFF_FFFF);
        for (int i = 0; i < 9; i++)
            send_item(ACT_ADD, KEY_W'(1 + 16 * i));
        send_item(ACT_ADD, 32'h0000_0001);
        send_item(ACT_LIST, 32'h0000_0081);
        send_item(ACT_ERASE, 32'h0000_0021);
        send_item(ACT_LIST, 32'h0000_0001);
        send_item(ACT_TEST, 32'hAAAA_AAAA);
        send_item(ACT_TEST, 32'h5555_5555);

        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            write_count(phase_counts[p]);
            idle_on = (p != 7) && (p % 3 != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_item();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: chained_hash_set.f
design/chs_pkg.sv
design/chs_mod_unit.sv
design/chs_regs.sv
design/chs_engine.sv
design/chained_hash_set.sv
tb/set_op_checker.sv
tb/tb.sv
